// ===== design/cesu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cesu_pkg
// shared types and character helpers for the escaped string decoder
// ---------------------------------------------------------------------------
package cesu_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } dec_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } digit_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } named_t;

    function automatic digit_t hex_digit(input logic [7:0] b);
        digit_t d;
        d.hit   = 1'b0;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.hit   = 1'b1;
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.hit   = 1'b1;
            d.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.hit   = 1'b1;
            d.value = 4'(b - 8'h37);
        end
        return d;
    endfunction

    function automatic digit_t oct_digit(input logic [7:0] b);
        digit_t d;
        d.hit   = (b >= 8'h30 && b <= 8'h37);
        d.value = {1'b0, b[2:0]};
        return d;
    endfunction

    function automatic named_t named_escape(input logic [7:0] b);
        named_t n;
        n.hit   = 1'b1;
        n.value = b;
        case (b)
            8'h5C:   n.value = 8'h5C;
            8'h22:   n.value = 8'h22;
            8'h27:   n.value = 8'h27;
            8'h61:   n.value = 8'h07;
            8'h62:   n.value = 8'h08;
            8'h66:   n.value = 8'h0C;
            8'h6E:   n.value = 8'h0A;
            8'h72:   n.value = 8'h0D;
            8'h74:   n.value = 8'h09;
            8'h76:   n.value = 8'h0B;
            default: n.hit   = 1'b0;
        endcase
        return n;
    endfunction

endpackage

// ===== design/c_string_unescaper_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c_string_unescaper_core
// decodes backslash escapes of a C string stream, one source byte per beat
// ---------------------------------------------------------------------------
// path: source beat in the input register, its results in the output buffer
// throughput: one source beat per cycle while its results fit the output buffer;
//   a beat that yields two results (flushed numeric escape plus a text byte)
//   waits for room for both; one result leaves per cycle while m_tready is high
// reset: synchronous, active low; clears parse state, input and output valids
module c_string_unescaper_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import cesu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    res_t       q_reg [2];
    res_t       q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] base, space;
    logic       pop, step, s_take;
    dec_t       dec;

    cesu_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte_reg),
        .in_eos  (in_eos_reg),
        .step    (step),
        .dec     (dec)
    );

    assign pop      = m_tvalid && m_tready;
    assign space    = 2'd2 - cnt_reg + {1'b0, pop};
    assign step     = in_valid_reg && (dec.count <= space);
    assign s_tready = !in_valid_reg || step;
    assign s_take   = s_tvalid && s_tready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;

    always_comb begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop) begin
            q_next[0] = q_reg[1];
        end
        base = cnt_reg - {1'b0, pop};
        if (step && dec.count != 2'd0) begin
            q_next[base[0]] = dec.first;
        end
        if (step && dec.count == 2'd2) begin
            q_next[1] = dec.second;
        end
        cnt_next = base + (step ? dec.count : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
        end
        if (s_take) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output buffer overfilled");

    a_step_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> cnt_next <= 2'd2)
        else $error("decoded results do not fit the output buffer");

    a_eos_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_eos_reg |-> dec.count != 2'd0)
        else $error("end of string beat produced no result");

endmodule

// ===== design/cesu_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cesu_parser
// escape parse state and single-pass decode of one source byte
// ---------------------------------------------------------------------------
module cesu_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    in_byte,
    input  logic          in_eos,
    input  logic          step,
    output cesu_pkg::dec_t dec
);
    import cesu_pkg::*;

    typedef enum logic [2:0] {
        PH_TEXT      = 3'd0,
        PH_BACKSLASH = 3'd1,
        PH_HEX0      = 3'd2,
        PH_HEX1      = 3'd3,
        PH_OCT1      = 3'd4,
        PH_OCT2      = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] acc_reg, acc_next;

    digit_t     hexd, octd;
    named_t     named;
    logic [8:0] oct_sum;
    logic       text_esc;
    res_t       flush_res, text_res;

    always_comb begin
        hexd      = hex_digit(in_byte);
        octd      = oct_digit(in_byte);
        named     = named_escape(in_byte);
        oct_sum   = {acc_reg[5:0], 3'b000} + {6'd0, octd.value[2:0]};
        text_esc  = (in_byte == CH_BACKSLASH) && !in_eos;
        flush_res = '{data: acc_reg[7:0], last: 1'b0};
        text_res  = '{data: in_byte, last: in_eos};

        dec        = '0;
        phase_next = PH_TEXT;
        acc_next   = 9'd0;

        unique case (phase_reg)
            PH_BACKSLASH: begin
                if (in_byte == CH_LOWER_X || in_byte == CH_UPPER_X) begin
                    if (in_eos) begin
                        dec.count = 2'd1;
                        dec.first = '{data: 8'h00, last: 1'b1};
                    end else begin
                        phase_next = PH_HEX0;
                    end
                end else if (octd.hit) begin
                    if (in_eos) begin
                        dec.count = 2'd1;
                        dec.first = '{data: {5'd0, octd.value[2:0]}, last: 1'b1};
                    end else begin
                        phase_next = PH_OCT1;
                        acc_next   = {6'd0, octd.value[2:0]};
                    end
                end else begin
                    dec.count = 2'd1;
                    dec.first = '{data: named.hit ? named.value : in_byte, last: in_eos};
                end
            end
            PH_HEX0, PH_HEX1: begin
                if (hexd.hit) begin
                    if (phase_reg == PH_HEX0) begin
                        if (in_eos) begin
                            dec.count = 2'd1;
                            dec.first = '{data: {4'd0, hexd.value}, last: 1'b1};
                        end else begin
                            phase_next = PH_HEX1;
                            acc_next   = {5'd0, hexd.value};
                        end
                    end else begin
                        dec.count = 2'd1;
                        dec.first = '{data: {acc_reg[3:0], hexd.value}, last: in_eos};
                    end
                end else begin
                    dec.first = flush_res;
                    if (text_esc) begin
                        dec.count  = 2'd1;
                        phase_next = PH_BACKSLASH;
                    end else begin
                        dec.count  = 2'd2;
                        dec.second = text_res;
                    end
                end
            end
            PH_OCT1, PH_OCT2: begin
                if (octd.hit) begin
                    if (phase_reg == PH_OCT1 && !in_eos) begin
                        phase_next = PH_OCT2;
                        acc_next   = oct_sum;
                    end else begin
                        dec.count = 2'd1;
                        dec.first = '{data: oct_sum[7:0], last: in_eos};
                    end
                end else begin
                    dec.first = flush_res;
                    if (text_esc) begin
                        dec.count  = 2'd1;
                        phase_next = PH_BACKSLASH;
                    end else begin
                        dec.count  = 2'd2;
                        dec.second = text_res;
                    end
                end
            end
            default: begin
                if (text_esc) begin
                    phase_next = PH_BACKSLASH;
                end else begin
                    dec.count = 2'd1;
                    dec.first = text_res;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            acc_reg   <= 9'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    a_eos_returns_to_text: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_eos |=> phase_reg == PH_TEXT && acc_reg == 9'd0)
        else $error("parse state not cleared after end of string");

    a_flush_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.count == 2'd2 |-> !dec.first.last)
        else $error("flushed value marked last");

    a_hex_acc_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEX1 |-> acc_reg[8:4] == 5'd0)
        else $error("hex accumulator holds more than one digit");

endmodule
